// ----- design/pils_pkg.sv -----
// ----------------------------------------------------------------------------
// pils_pkg
// Shared types and constants of the position-indexed list store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pils_pkg;

    localparam int DEPTH  = 64;
    localparam int WIDTH  = 32;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int CMPW   = (CW > 8) ? CW : 8;
    localparam int POS_W  = 8;
    localparam int VAL_W  = 32;
    localparam int KIND_W = 3;
    localparam int CNT_W  = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 3'd0,
        KIND_DELETE = 3'd1,
        KIND_GET    = 3'd2,
        KIND_LOCATE = 3'd3,
        KIND_CLEAR  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  position;
        logic [VAL_W-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [VAL_W-1:0] element;
        logic [CNT_W-1:0] found_at;
        logic [CNT_W-1:0] count;
    } rsp_t;

    typedef struct packed {
        logic             wr_en;
        logic [AW-1:0]    wr_addr;
        logic [WIDTH-1:0] wr_data;
        logic             rd_en;
        logic [AW-1:0]    rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic valid;
        rsp_t beat;
    } res_t;

endpackage

`default_nettype wire

// ----- design/pils_ram.sv -----
// ----------------------------------------------------------------------------
// pils_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pils_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] ram_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- design/pils_ctrl.sv -----
// ----------------------------------------------------------------------------
// pils_ctrl
// Operation sequencer: range checks, element shifting, get and linear search
// through the list RAM, one element per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pils_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cmd_valid,
    output logic                          cmd_stall,
    input  wire pils_pkg::cmd_t           cmd,
    input  wire logic                     load,
    output pils_pkg::res_t                res,
    output pils_pkg::mem_req_t            mem,
    input  wire logic [pils_pkg::WIDTH-1:0] rd_data
);

    import pils_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_DEL,
        S_GET_RD,
        S_GET_DATA,
        S_LOC,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic             pend_reg, pend_next;
    logic [AW-1:0]    wa_reg, wa_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [WIDTH-1:0] val_reg, val_next;
    status_t          st_reg, st_next;
    logic [VAL_W-1:0] elem_reg, elem_next;
    logic [CNT_W-1:0] found_reg, found_next;

    logic [CMPW-1:0]  cmd_pos_w;
    logic [CMPW-1:0]  fill_w;
    logic [CMPW-1:0]  idx_w;
    logic [CMPW-1:0]  pos_w;
    logic             ins_bad;
    logic             acc_bad;

    assign cmd_pos_w = CMPW'(cmd.position);
    assign fill_w    = CMPW'(fill_reg);
    assign idx_w     = CMPW'(idx_reg);
    assign pos_w     = CMPW'(pos_reg);
    assign ins_bad   = (cmd.position == '0) || (cmd_pos_w > fill_w + CMPW'(1));
    assign acc_bad   = (cmd.position == '0) || (cmd_pos_w > fill_w);

    assign cmd_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        wa_next    = wa_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        st_next    = st_reg;
        elem_next  = elem_reg;
        found_next = found_reg;
        mem        = '0;

        res.valid         = (state_reg == S_DONE);
        res.beat.status   = st_reg;
        res.beat.element  = elem_reg;
        res.beat.found_at = found_reg;
        res.beat.count    = CNT_W'(fill_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    pos_next   = cmd.position;
                    val_next   = WIDTH'(cmd.value);
                    elem_next  = '0;
                    found_next = '0;
                    st_next    = ST_OK;
                    pend_next  = 1'b0;
                    unique case (cmd.kind)
                        KIND_INSERT:
                        begin
                            if (ins_bad)
                            begin
                                st_next    = ST_RANGE;
                                state_next = S_DONE;
                            end
                            else if (fill_reg == CW'(DEPTH))
                            begin
                                st_next    = ST_FULL;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                idx_next   = fill_reg;
                                state_next = S_INS;
                            end
                        end
                        KIND_DELETE:
                        begin
                            if (acc_bad)
                            begin
                                st_next    = ST_RANGE;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                idx_next   = CW'(cmd.position) - CW'(1);
                                state_next = S_DEL;
                            end
                        end
                        KIND_GET:
                        begin
                            if (acc_bad)
                            begin
                                st_next    = ST_RANGE;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                idx_next   = CW'(cmd.position) - CW'(1);
                                state_next = S_GET_RD;
                            end
                        end
                        KIND_LOCATE:
                        begin
                            st_next    = ST_MISS;
                            idx_next   = '0;
                            state_next = S_LOC;
                        end
                        KIND_CLEAR:
                        begin
                            fill_next  = '0;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            st_next    = ST_RANGE;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_INS:
            begin
                // element read last cycle lands one slot higher
                if (pend_reg)
                begin
                    mem.wr_en   = 1'b1;
                    mem.wr_addr = wa_reg;
                    mem.wr_data = rd_data;
                end
                if (idx_w >= pos_w)
                begin
                    mem.rd_en   = 1'b1;
                    mem.rd_addr = AW'(idx_reg - CW'(1));
                    pend_next   = 1'b1;
                    wa_next     = AW'(idx_reg);
                    idx_next    = idx_reg - CW'(1);
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    mem.wr_en   = 1'b1;
                    mem.wr_addr = AW'(pos_reg - POS_W'(1));
                    mem.wr_data = val_reg;
                    fill_next   = fill_reg + CW'(1);
                    state_next  = S_DONE;
                end
            end
            S_DEL:
            begin
                // element read last cycle lands one slot lower
                if (pend_reg)
                begin
                    mem.wr_en   = 1'b1;
                    mem.wr_addr = wa_reg;
                    mem.wr_data = rd_data;
                end
                if (idx_reg + CW'(1) < fill_reg)
                begin
                    mem.rd_en   = 1'b1;
                    mem.rd_addr = AW'(idx_reg + CW'(1));
                    pend_next   = 1'b1;
                    wa_next     = AW'(idx_reg);
                    idx_next    = idx_reg + CW'(1);
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    fill_next  = fill_reg - CW'(1);
                    state_next = S_DONE;
                end
            end
            S_GET_RD:
            begin
                mem.rd_en   = 1'b1;
                mem.rd_addr = AW'(idx_reg);
                state_next  = S_GET_DATA;
            end
            S_GET_DATA:
            begin
                elem_next  = VAL_W'(rd_data);
                state_next = S_DONE;
            end
            S_LOC:
            begin
                // compare the beat read last cycle, issue the next read
                if (pend_reg && (rd_data == val_reg))
                begin
                    st_next    = ST_OK;
                    found_next = CNT_W'({1'b0, wa_reg} + 1'b1);
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                end
                else if (idx_reg < fill_reg)
                begin
                    mem.rd_en   = 1'b1;
                    mem.rd_addr = AW'(idx_reg);
                    pend_next   = 1'b1;
                    wa_next     = AW'(idx_reg);
                    idx_next    = idx_reg + CW'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        wa_reg    <= wa_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        st_reg    <= st_next;
        elem_reg  <= elem_next;
        found_reg <= found_next;
    end

    a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("fill above capacity");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !mem.wr_en)
        else $error("ram write outside an operation");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.beat.status == ST_FULL) |-> (fill_reg == CW'(DEPTH)))
        else $error("full status with room left");

    a_loc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (mem.rd_en && state_reg == S_LOC) |-> (CW'(mem.rd_addr) < fill_reg))
        else $error("search read beyond fill");

endmodule

`default_nettype wire

// ----- design/position_indexed_list_store_core.sv -----
// ----------------------------------------------------------------------------
// position_indexed_list_store_core
// Ordered list of up to DEPTH elements with insert, delete, get, locate and
// clear by 1-based position; one result beat per command beat.
// ----------------------------------------------------------------------------
// flow: clear and rejected commands go straight to the result, get reads one
//   element, insert/delete shift the tail, locate scans to the first match
// throughput: one command at a time; cmd_stall stays high until the result
//   has been loaded into the output register, which waits while a full
//   output register is stalled by rsp_stall
// reset: count clears to zero at once; the RAM holds no reset state
`timescale 1ns / 1ps
`default_nettype none

module position_indexed_list_store_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_stall,
    input  wire pils_pkg::cmd_t cmd,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output pils_pkg::rsp_t      rsp
);

    import pils_pkg::*;

    res_t             res;
    mem_req_t         mem;
    logic [WIDTH-1:0] rd_data;
    logic             load;
    logic             out_valid_reg, out_valid_next;
    rsp_t             out_reg;

    pils_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .load      (load),
        .res       (res),
        .mem       (mem),
        .rd_data   (rd_data)
    );

    pils_ram #(
        .DATA_W (WIDTH),
        .DEPTH  (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem.wr_en),
        .wr_addr (mem.wr_addr),
        .wr_data (mem.wr_data),
        .rd_en   (mem.rd_en),
        .rd_addr (mem.rd_addr),
        .rd_data (rd_data)
    );

    // output register takes a result when empty or being drained
    assign load = res.valid && (!out_valid_reg || !rsp_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= res.beat;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire

// ----- test/tb_position_indexed_list_store_core.sv -----
// ----------------------------------------------------------------------------
// tb_position_indexed_list_store_core
// Self-checking bench for the ordered list store: drives insert, delete, get,
// locate and clear commands with random gaps on both channels, tracks the list
// contents alongside the core, and compares every reply field against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_position_indexed_list_store_core;

    import pils_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = 3'd5;
    localparam int IDLE_PCT     = 36;
    localparam int BLOCK_ITEMS  = 80;
    localparam int ITEM_TARGET  = 900;
    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = DEPTH + 16;

    // shadow copy of the list and the replies it implies, in command order
    class list_tracker;
        logic [WIDTH-1:0] slots [DEPTH];
        int               fill;
        rsp_t             pending_replies [$];
        int unsigned      errors;
        int unsigned      kind_tally [8];
        int unsigned      status_tally [4];
        int               peak_fill;

        function new();
            fill = 0;
            errors = 0;
            peak_fill = 0;
            foreach (kind_tally[i]) kind_tally[i] = 0;
            foreach (status_tally[i]) status_tally[i] = 0;
        endfunction

        function void apply_command(cmd_t c);
            rsp_t r;
            int   p;
            int   j;
            r = '0;
            r.status = ST_OK;
            p = c.position;
            kind_tally[c.kind]++;
            case (c.kind)
                KIND_INSERT:
                begin
                    if (p < 1 || p > fill + 1)
                        r.status = ST_RANGE;
                    else if (fill >= DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        for (j = fill; j > p - 1; j--)
                            slots[j] = slots[j - 1];
                        slots[p - 1] = c.value[WIDTH-1:0];
                        fill++;
                    end
                end
                KIND_DELETE:
                begin
                    if (p < 1 || p > fill)
                        r.status = ST_RANGE;
                    else
                    begin
                        for (j = p - 1; j + 1 < fill; j++)
                            slots[j] = slots[j + 1];
                        fill--;
                    end
                end
                KIND_GET:
                begin
                    if (p < 1 || p > fill)
                        r.status = ST_RANGE;
                    else
                        r.element = VAL_W'(slots[p - 1]);
                end
                KIND_LOCATE:
                begin
                    r.status = ST_MISS;
                    for (j = 0; j < fill && r.status == ST_MISS; j++)
                    begin
                        if (slots[j] == c.value[WIDTH-1:0])
                        begin
                            r.status = ST_OK;
                            r.found_at = CNT_W'(j + 1);
                        end
                    end
                end
                KIND_CLEAR:
                    fill = 0;
                default:
                    r.status = ST_RANGE;
            endcase
            r.count = CNT_W'(fill);
            if (fill > peak_fill)
                peak_fill = fill;
            status_tally[r.status]++;
            pending_replies.push_back(r);
        endfunction

        function void flag_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: reply %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, name, want, got);
            end
        endfunction

        function void compare_reply(rsp_t got);
            rsp_t want;
            if (pending_replies.size() == 0)
            begin
                errors++;
                $display("%0t: reply beat with nothing outstanding, expected none, got %p",
                         $time, got);
                return;
            end
            want = pending_replies.pop_front();
            flag_field("status", VAL_W'(want.status), VAL_W'(got.status));
            flag_field("element", want.element, got.element);
            flag_field("found_at", VAL_W'(want.found_at), VAL_W'(got.found_at));
            flag_field("count", VAL_W'(want.count), VAL_W'(got.count));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    cmd_t        cmd = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_t        rsp;

    list_tracker tracker = new();
    bit          steady = 1'b0;
    int          items_sent = 0;
    int          quiet_cycles = 0;

    position_indexed_list_store_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
        rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
                tracker.apply_command(cmd);
            if (rsp_valid && !rsp_stall)
                tracker.compare_reply(rsp);
        end
    end

    // no beat on either channel for too long means the core is hung
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles, %0d replies outstanding",
                         $time, QUIET_LIMIT, tracker.pending_replies.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic cmd_t make_cmd(logic [KIND_W-1:0] k, int p, logic [VAL_W-1:0] v);
        cmd_t c;
        c.kind = k;
        c.position = POS_W'(p);
        c.value = v;
        return c;
    endfunction

    // small values give duplicates so locate has to pick the first match
    function automatic logic [VAL_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 25)
            return VAL_W'($urandom_range(7));
        else if (roll < 30)
            return '0;
        else if (roll < 35)
            return '1;
        return $urandom;
    endfunction

    function automatic cmd_t pick_command(int insert_pct, int delete_pct);
        cmd_t c;
        int   f;
        int   roll;
        int   p;
        f = tracker.fill;
        roll = $urandom_range(99);
        if (roll < 6)
            return make_cmd(3'($urandom_range(7)), $urandom_range(255), $urandom);
        roll = $urandom_range(99);
        c = make_cmd(KIND_GET, 0, pick_value());
        if (roll < 2)
            c.kind = KIND_CLEAR;
        else if (roll < 2 + insert_pct)
            c.kind = KIND_INSERT;
        else if (roll < 2 + insert_pct + delete_pct)
            c.kind = KIND_DELETE;
        else if (roll & 1)
            c.kind = KIND_LOCATE;
        if (c.kind == KIND_LOCATE && f > 0 && $urandom_range(99) < 60)
            c.value = VAL_W'(tracker.slots[$urandom_range(f - 1)]);
        if ($urandom_range(99) < 88)
        begin
            if (c.kind == KIND_INSERT)
                p = $urandom_range(f + 1, 1);
            else
                p = (f > 0) ? $urandom_range(f, 1) : 1;
        end
        else
        begin
            case ($urandom_range(2))
                0: p = 0;
                1: p = (c.kind == KIND_INSERT) ? f + 2 : f + 1;
                default: p = $urandom_range(255);
            endcase
        end
        c.position = POS_W'(p);
        return c;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_command(input cmd_t c);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            cmd_valid = 1'b0;
            @(negedge clk);
        end
        cmd = c;
        cmd_valid = 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // grow to capacity, then knock on the full list
    task automatic fill_to_capacity();
        while (tracker.fill < DEPTH)
            send_command(make_cmd(KIND_INSERT, $urandom_range(tracker.fill + 1, 1),
                                  pick_value()));
        send_command(make_cmd(KIND_INSERT, DEPTH + 1, $urandom));
        send_command(make_cmd(KIND_INSERT, 1, $urandom));
        send_command(make_cmd(KIND_INSERT, DEPTH + 2, $urandom));
        send_command(make_cmd(KIND_GET, DEPTH, '0));
        send_command(make_cmd(KIND_LOCATE, 0, VAL_W'(tracker.slots[DEPTH - 1])));
    endtask

    initial
    begin
        cmd_t directed [$];
        int   block;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed = '{
            make_cmd(KIND_GET, 1, '0),
            make_cmd(KIND_DELETE, 1, '0),
            make_cmd(KIND_LOCATE, 0, '0),
            make_cmd(KIND_INSERT, 0, 32'h1234_5678),
            make_cmd(KIND_INSERT, 2, 32'h1234_5678),
            make_cmd(KIND_INSERT, 1, '0),
            make_cmd(KIND_INSERT, 2, '1),
            make_cmd(KIND_INSERT, 1, 32'h5a5a_5a5a),
            make_cmd(KIND_INSERT, 2, 32'ha5a5_a5a5),
            make_cmd(KIND_GET, 1, '1),
            make_cmd(KIND_GET, 4, '0),
            make_cmd(KIND_GET, 5, '0),
            make_cmd(KIND_LOCATE, 0, '1),
            make_cmd(KIND_INSERT, 5, '0),
            make_cmd(KIND_LOCATE, 255, '0),
            make_cmd(KIND_LOCATE, 1, 32'h0bad_cafe),
            make_cmd(KIND_DELETE, 2, '0),
            make_cmd(KIND_DELETE, 4, '0),
            make_cmd(KIND_DELETE, 4, '0),
            make_cmd(KIND_DELETE, 0, '0),
            make_cmd(KIND_SPARE, 1, '1),
            make_cmd(KIND_SPARE + 3'd1, 255, '0),
            make_cmd(KIND_SPARE + 3'd2, 2, 32'hffff_0000),
            make_cmd(KIND_INSERT, 255, '1),
            make_cmd(KIND_CLEAR, 255, '1)
        };
        foreach (directed[i])
            send_command(directed[i]);

        fill_to_capacity();
        block = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (block == 6)
                fill_to_capacity();
            steady = (block == 4);
            repeat (BLOCK_ITEMS)
            begin
                case (block % 3)
                    0: send_command(pick_command(55, 15));
                    1: send_command(pick_command(30, 25));
                    default: send_command(pick_command(12, 50));
                endcase
            end
            block++;
        end
        steady = 1'b0;
        cmd_valid = 1'b0;

        while (tracker.pending_replies.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d commands: insert %0d, delete %0d, get %0d, locate %0d, clear %0d",
                 items_sent, tracker.kind_tally[KIND_INSERT], tracker.kind_tally[KIND_DELETE],
                 tracker.kind_tally[KIND_GET], tracker.kind_tally[KIND_LOCATE],
                 tracker.kind_tally[KIND_CLEAR]);
        $display("statuses ok %0d, range %0d, full %0d, miss %0d; peak fill %0d of %0d",
                 tracker.status_tally[ST_OK], tracker.status_tally[ST_RANGE],
                 tracker.status_tally[ST_FULL], tracker.status_tally[ST_MISS],
                 tracker.peak_fill, DEPTH);
        if (tracker.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
